>>> sv/rst_pkg.sv
// Package for the ring successor table: field widths, codes, command and
// result types shared by the front end, the queue and the engine.
// Depends on nothing.
package rst_pkg;

   localparam int MAX_MEMBERS_DEF = 64;
   localparam int ID_WIDTH_DEF    = 64;
   localparam int QUEUE_DEPTH     = 2;

   localparam int KEY_W  = 64;
   localparam int ADDR_W = 32;
   localparam int PORT_W = 16;
   localparam int FIDX_W = 6;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_FINGER = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_DUP   = 3'd1,
      ST_COLL  = 3'd2,
      ST_FULL  = 3'd3,
      ST_EMPTY = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      E_IDLE,
      E_SCAN,
      E_DECIDE,
      E_SHRD,
      E_SHWR,
      E_INSWR,
      E_EMIT
   } eng_state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  id;
      logic [ADDR_W-1:0] addr;
      logic [PORT_W-1:0] port;
   } member_type;

   typedef struct packed {
      op_type     op;
      member_type member;
   } cmd_type;

   typedef struct packed {
      status_type        status;
      member_type        succ;
      member_type        pred;
      logic [FIDX_W-1:0] finger_index;
      logic              last;
   } res_type;

   // A single closing result that carries only a status.
   function automatic res_type status_res(input status_type st);
      res_type r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      return r;
   endfunction

endpackage

>>> sv/rst_front.sv
// Front end of the ring successor table: registers each request, decodes
// its opcode and hands the command to the queue. Depends on rst_pkg.
module rst_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_opcode,
   input  logic [rst_pkg::KEY_W-1:0]  req_key,
   input  logic [rst_pkg::ADDR_W-1:0] req_member_addr,
   input  logic [rst_pkg::PORT_W-1:0] req_member_port,
   input  logic                       q_full,
   output logic                       q_push,
   output rst_pkg::cmd_type           q_cmd
);
   import rst_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = valid_ff && !q_full;
   assign q_cmd     = cmd_ff;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (accept) begin
         valid_in         = 1'b1;
         cmd_in.op        = op_type'(req_opcode);
         cmd_in.member.id   = req_key;
         cmd_in.member.addr = req_member_addr;
         cmd_in.member.port = req_member_port;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

>>> sv/rst_queue.sv
// Short command queue between the front end and the engine.
// Depends on rst_pkg.
module rst_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rst_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output rst_pkg::cmd_type pop_cmd
);
   import rst_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full      = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_cmd   = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

>>> sv/rst_engine.sv
// Back end of the ring successor table: the sorted member memory, the scan
// sequencer for lookups and fingers, the insertion shifter and the result
// register. Depends on rst_pkg.
module rst_engine #(
   parameter int MAX_MEMBERS = rst_pkg::MAX_MEMBERS_DEF,
   parameter int ID_WIDTH    = rst_pkg::ID_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  rst_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rst_pkg::res_type rsp_res
);
   import rst_pkg::*;

   localparam int MA_W  = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
   localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

   member_type         mem [MAX_MEMBERS];
   member_type         rdata_ff;

   eng_state_type      state_ff, state_in;
   cmd_type            cmd_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [KEY_W-1:0]   target_ff;
   logic [CNT_W-1:0]   rd_ff;
   logic               dv_ff;
   logic [MA_W-1:0]    di_ff;
   logic               found_ff;
   logic [CNT_W-1:0]   pos_ff;
   logic [CNT_W-1:0]   j_ff;
   member_type         succ_ff, pred_ff, prev_ff, head_ff, tail_ff;
   logic [FIDX_W-1:0]  fidx_ff;
   res_type            res_ff;
   res_type            rsp_ff;
   logic               rsp_valid_ff;

   logic               out_free;
   logic               issue;
   logic [MA_W-1:0]    raddr;
   logic               mem_we;
   logic [MA_W-1:0]    waddr;
   member_type         wdata;
   logic               scan_done;
   logic               is_full;
   logic               fingers_done;
   logic [FIDX_W-1:0]  fidx_next;
   res_type            dec_res;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res      = rsp_ff;
   assign scan_done    = dv_ff && (di_ff == MA_W'(count_ff - 1'b1));
   assign is_full      = (count_ff == CNT_W'(MAX_MEMBERS));
   assign fingers_done = (fidx_ff == FIDX_W'(ID_WIDTH - 1));
   assign fidx_next    = fidx_ff + 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         E_IDLE: begin
            if (q_valid) begin
               case (q_cmd.op)
                  OP_CLEAR:  state_in = E_EMIT;
                  OP_INSERT: state_in = (count_ff == '0) ? E_INSWR : E_SCAN;
                  default:   state_in = (count_ff == '0) ? E_EMIT : E_SCAN;
               endcase
            end
         end
         E_SCAN: begin
            if (scan_done) begin
               state_in = E_DECIDE;
            end
         end
         E_DECIDE: begin
            if (cmd_ff.op == OP_INSERT && !(found_ff && succ_ff.id == cmd_ff.member.id)
                && !is_full) begin
               state_in = E_SHRD;
            end else begin
               state_in = E_EMIT;
            end
         end
         E_SHRD: begin
            state_in = (j_ff == pos_ff) ? E_INSWR : E_SHWR;
         end
         E_SHWR:  state_in = E_SHRD;
         E_INSWR: state_in = E_EMIT;
         E_EMIT: begin
            if (out_free) begin
               state_in = (cmd_ff.op == OP_FINGER && !res_ff.last) ? E_SCAN : E_IDLE;
            end
         end
         default: state_in = E_IDLE;
      endcase
   end

   // Memory port and queue control.
   always_comb begin
      q_pop  = 1'b0;
      issue  = 1'b0;
      raddr  = rd_ff[MA_W-1:0];
      mem_we = 1'b0;
      waddr  = pos_ff[MA_W-1:0];
      wdata  = cmd_ff.member;
      case (state_ff)
         E_IDLE: q_pop = q_valid;
         E_SCAN: issue = (rd_ff < count_ff);
         E_SHRD: raddr = MA_W'(j_ff - 1'b1);
         E_SHWR: begin
            mem_we = 1'b1;
            waddr  = j_ff[MA_W-1:0];
            wdata  = rdata_ff;
         end
         E_INSWR: mem_we = 1'b1;
         default: ;
      endcase
   end

   // Result of a finished scan, before any insertion shift.
   always_comb begin
      dec_res = status_res(ST_OK);
      case (cmd_ff.op)
         OP_LOOKUP: begin
            dec_res.succ = found_ff ? succ_ff : head_ff;
            dec_res.pred = (found_ff && pos_ff != '0) ? pred_ff : tail_ff;
         end
         OP_FINGER: begin
            dec_res.succ         = found_ff ? succ_ff : head_ff;
            dec_res.finger_index = fidx_ff;
            dec_res.last         = fingers_done;
         end
         default: begin
            if (found_ff && succ_ff.id == cmd_ff.member.id) begin
               dec_res.status = (succ_ff.addr == cmd_ff.member.addr
                                 && succ_ff.port == cmd_ff.member.port)
                                ? ST_DUP : ST_COLL;
            end else if (is_full) begin
               dec_res.status = ST_FULL;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dv_ff    <= issue;
         if (state_ff == E_IDLE && q_valid && q_cmd.op == OP_CLEAR) begin
            count_ff <= '0;
         end else if (state_ff == E_INSWR) begin
            count_ff <= count_ff + 1'b1;
         end
         if (state_ff == E_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (issue) begin
         rd_ff <= rd_ff + 1'b1;
      end
      di_ff <= rd_ff[MA_W-1:0];

      case (state_ff)
         E_IDLE: begin
            cmd_ff   <= q_cmd;
            rd_ff    <= '0;
            found_ff <= 1'b0;
            pos_ff   <= '0;
            fidx_ff  <= '0;
            if (q_cmd.op == OP_FINGER) begin
               target_ff <= q_cmd.member.id + KEY_W'(1);
            end else begin
               target_ff <= q_cmd.member.id;
            end
            if (q_cmd.op == OP_CLEAR) begin
               res_ff <= status_res(ST_OK);
            end else begin
               res_ff <= status_res(ST_EMPTY);
            end
         end
         E_SCAN: begin
            if (dv_ff) begin
               if (di_ff == '0) begin
                  head_ff <= rdata_ff;
               end
               if (!found_ff && rdata_ff.id >= target_ff) begin
                  found_ff <= 1'b1;
                  pos_ff   <= CNT_W'(di_ff);
                  succ_ff  <= rdata_ff;
                  pred_ff  <= prev_ff;
               end
               prev_ff <= rdata_ff;
               tail_ff <= rdata_ff;
            end
         end
         E_DECIDE: begin
            res_ff <= dec_res;
            if (cmd_ff.op == OP_INSERT) begin
               if (!found_ff) begin
                  pos_ff <= count_ff;
               end
               j_ff <= count_ff;
            end
         end
         E_SHWR: j_ff <= j_ff - 1'b1;
         E_INSWR: res_ff <= status_res(ST_OK);
         E_EMIT: begin
            if (out_free) begin
               rsp_ff <= res_ff;
               // The next finger restarts the scan with a fresh target.
               rd_ff     <= '0;
               found_ff  <= 1'b0;
               fidx_ff   <= fidx_next;
               target_ff <= cmd_ff.member.id + (KEY_W'(1) << fidx_next);
            end
         end
         default: ;
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_MEMBERS))
      else $error("member count exceeds table size");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == E_IDLE && q_valid && q_cmd.op == OP_CLEAR) |=> count_ff == '0)
      else $error("clear did not empty the table");

   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == E_SHRD) |-> j_ff >= pos_ff)
      else $error("insertion shift ran past its slot");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      dv_ff |-> (state_ff == E_SCAN || state_ff == E_DECIDE))
      else $error("scan read data outside a scan");

endmodule

>>> sv/ring_successor_table.sv
// Ring successor table. One request is handled at a time. Clear replies without
// a scan; an insert scans the single-port member memory, then shifts the members
// above its slot and writes the new one (no scan into an empty table, no shift
// when rejected), and a lookup is one scan of the member memory. Building fingers
// takes one full scan per finger, ID_WIDTH scans in all.
// Reset empties the table; the member memory itself is not cleared.
module ring_successor_table #(
   parameter int MAX_MEMBERS = rst_pkg::MAX_MEMBERS_DEF,
   parameter int ID_WIDTH    = rst_pkg::ID_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_opcode,
   input  logic [rst_pkg::KEY_W-1:0]  req_key,
   input  logic [rst_pkg::ADDR_W-1:0] req_member_addr,
   input  logic [rst_pkg::PORT_W-1:0] req_member_port,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic [rst_pkg::KEY_W-1:0]  rsp_succ_id,
   output logic [rst_pkg::ADDR_W-1:0] rsp_succ_addr,
   output logic [rst_pkg::PORT_W-1:0] rsp_succ_port,
   output logic [rst_pkg::KEY_W-1:0]  rsp_pred_id,
   output logic [rst_pkg::ADDR_W-1:0] rsp_pred_addr,
   output logic [rst_pkg::PORT_W-1:0] rsp_pred_port,
   output logic [rst_pkg::FIDX_W-1:0] rsp_finger_index,
   output logic                       rsp_last
);
   import rst_pkg::*;

   logic    q_full, q_push, q_valid, q_pop;
   cmd_type push_cmd, pop_cmd;
   res_type res;

   rst_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .req_member_addr (req_member_addr),
      .req_member_port (req_member_port),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   rst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (pop_cmd)
   );

   rst_engine #(
      .MAX_MEMBERS (MAX_MEMBERS),
      .ID_WIDTH    (ID_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (pop_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (res)
   );

   assign rsp_status       = res.status;
   assign rsp_succ_id      = res.succ.id;
   assign rsp_succ_addr    = res.succ.addr;
   assign rsp_succ_port    = res.succ.port;
   assign rsp_pred_id      = res.pred.id;
   assign rsp_pred_addr    = res.pred.addr;
   assign rsp_pred_port    = res.pred.port;
   assign rsp_finger_index = res.finger_index;
   assign rsp_last         = res.last;

endmodule

>>> sim/ring_successor_table_tb.sv
// Testbench for ring_successor_table: drives table commands through the request
// channel and checks every reply against a behavioural copy of the member table
// or a fixed expected status. Depends on rst_pkg and the ring_successor_table RTL.
`timescale 1ns / 100ps

module ring_successor_table_tb;
   import rst_pkg::*;

   localparam int MEMBERS    = 64;
   localparam int FINGERS    = 64;
   localparam int CYCLE_CAP  = 8_000_000;
   localparam int LONG_HOLD  = 400;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_opcode;
   logic [KEY_W-1:0]  req_key;
   logic [ADDR_W-1:0] req_member_addr;
   logic [PORT_W-1:0] req_member_port;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [2:0]        rsp_status;
   logic [KEY_W-1:0]  rsp_succ_id;
   logic [ADDR_W-1:0] rsp_succ_addr;
   logic [PORT_W-1:0] rsp_succ_port;
   logic [KEY_W-1:0]  rsp_pred_id;
   logic [ADDR_W-1:0] rsp_pred_addr;
   logic [PORT_W-1:0] rsp_pred_port;
   logic [FIDX_W-1:0] rsp_finger_index;
   logic              rsp_last;

   ring_successor_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_key(req_key), .req_member_addr(req_member_addr),
      .req_member_port(req_member_port),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_succ_id(rsp_succ_id), .rsp_succ_addr(rsp_succ_addr),
      .rsp_succ_port(rsp_succ_port), .rsp_pred_id(rsp_pred_id),
      .rsp_pred_addr(rsp_pred_addr), .rsp_pred_port(rsp_pred_port),
      .rsp_finger_index(rsp_finger_index), .rsp_last(rsp_last)
   );

   // Shadow copy of the sorted member table.
   logic [KEY_W-1:0]  ring_id   [MEMBERS];
   logic [ADDR_W-1:0] ring_addr [MEMBERS];
   logic [PORT_W-1:0] ring_port [MEMBERS];
   int                ring_count;

   res_type pending_replies[$];
   int      error_count;
   int      cycle_count;
   bit      calm;
   bit      long_hold;

   typedef struct {
      op_type            op;
      logic [KEY_W-1:0]  key;
      logic [ADDR_W-1:0] addr;
      logic [PORT_W-1:0] port;
      bit                typed;
      status_type        st;
   } stim_row;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int first_not_below(logic [KEY_W-1:0] k);
      int i;
      for (i = 0; i < ring_count; i++)
         if (ring_id[i] >= k) return i;
      return ring_count;
   endfunction

   function automatic member_type ring_entry(int i);
      member_type m;
      m.id   = ring_id[i];
      m.addr = ring_addr[i];
      m.port = ring_port[i];
      return m;
   endfunction

   // Applies one command to the shadow table and returns the replies it causes.
   function automatic void predict_replies(op_type op, logic [KEY_W-1:0] key,
                                           logic [ADDR_W-1:0] addr,
                                           logic [PORT_W-1:0] port,
                                           ref res_type replies[$]);
      int idx, j, s, p;
      res_type r;
      replies = {};
      case (op)
         OP_CLEAR: begin
            ring_count = 0;
            replies = {replies, status_res(ST_OK)};
         end
         OP_INSERT: begin
            idx = first_not_below(key);
            if (idx < ring_count && ring_id[idx] == key) begin
               if (ring_addr[idx] == addr && ring_port[idx] == port)
                  replies = {replies, status_res(ST_DUP)};
               else
                  replies = {replies, status_res(ST_COLL)};
            end else if (ring_count >= MEMBERS) begin
               replies = {replies, status_res(ST_FULL)};
            end else begin
               for (j = ring_count; j > idx; j--) begin
                  ring_id[j]   = ring_id[j-1];
                  ring_addr[j] = ring_addr[j-1];
                  ring_port[j] = ring_port[j-1];
               end
               ring_id[idx]   = key;
               ring_addr[idx] = addr;
               ring_port[idx] = port;
               ring_count++;
               replies = {replies, status_res(ST_OK)};
            end
         end
         default: begin
            if (ring_count == 0) begin
               replies = {replies, status_res(ST_EMPTY)};
            end else if (op == OP_LOOKUP) begin
               idx = first_not_below(key);
               s = (idx == ring_count) ? 0 : idx;
               p = (idx == 0) ? ring_count - 1 : idx - 1;
               r = status_res(ST_OK);
               r.succ = ring_entry(s);
               r.pred = ring_entry(p);
               replies = {replies, r};
            end else begin
               for (j = 0; j < FINGERS; j++) begin
                  idx = first_not_below(key + (64'd1 << j));
                  if (idx == ring_count) idx = 0;
                  r = '0;
                  r.status       = ST_OK;
                  r.succ         = ring_entry(idx);
                  r.finger_index = FIDX_W'(j);
                  r.last         = (j == FINGERS - 1);
                  replies = {replies, r};
               end
            end
         end
      endcase
   endfunction

   // Offers one request and waits for it to be taken.
   task automatic send_request(stim_row row);
      res_type replies[$];
      @(negedge clock);
      req_valid       = 1'b1;
      req_opcode      = row.op;
      req_key         = row.key;
      req_member_addr = row.addr;
      req_member_port = row.port;
      do @(posedge clock); while (req_stall);
      predict_replies(row.op, row.key, row.addr, row.port, replies);
      if (row.typed) pending_replies = {pending_replies, status_res(row.st)};
      else foreach (replies[i]) pending_replies = {pending_replies, replies[i]};
   endtask

   task automatic sender_gap();
      if (!calm && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (ring_count > 0 && sel >= 6 && sel <= 7)
         return ring_id[$urandom_range(0, ring_count - 1)];
      if (ring_count > 0 && sel == 8)
         return ring_id[$urandom_range(0, ring_count - 1)]
                + ($urandom_range(0, 1) ? 64'd1 : '1);
      if (sel == 9) return $urandom_range(0, 1) ? '0 : '1;
      return {$urandom, $urandom};
   endfunction

   function automatic stim_row random_row(op_type op);
      stim_row row;
      int idx;
      row.op    = op;
      row.key   = pick_key();
      row.addr  = $urandom;
      row.port  = PORT_W'($urandom);
      row.typed = 1'b0;
      row.st    = ST_OK;
      idx = first_not_below(row.key);
      // Repeated identifiers come back with the stored address and port half the time.
      if (idx < ring_count && ring_id[idx] == row.key && $urandom_range(0, 1)) begin
         row.addr = ring_addr[idx];
         row.port = ring_port[idx];
      end
      return row;
   endfunction

   function automatic op_type random_op();
      int w;
      w = $urandom_range(0, 99);
      if (w < 3) return OP_CLEAR;
      if (w < 55) return OP_INSERT;
      if (w < 92) return OP_LOOKUP;
      return OP_FINGER;
   endfunction

   // Receiver: random stall bursts, a single long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall = 1'b0;
            long_hold = 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(20, 60)) @(negedge clock);
         end
      end
   end

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, got_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      res_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $error("reply with nothing expected: status %0d", rsp_status);
            error_count++;
         end else begin
            e = pending_replies.pop_front();
            check_field("status", 64'(e.status), 64'(rsp_status));
            check_field("succ_id", e.succ.id, rsp_succ_id);
            check_field("succ_addr", 64'(e.succ.addr), 64'(rsp_succ_addr));
            check_field("succ_port", 64'(e.succ.port), 64'(rsp_succ_port));
            check_field("pred_id", e.pred.id, rsp_pred_id);
            check_field("pred_addr", 64'(e.pred.addr), 64'(rsp_pred_addr));
            check_field("pred_port", 64'(e.pred.port), 64'(rsp_pred_port));
            check_field("finger_index", 64'(e.finger_index), 64'(rsp_finger_index));
            check_field("last", 64'(e.last), 64'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("ring_successor_table_tb: done, errors");
         $finish;
      end
   end

   stim_row directed[] = '{
      '{OP_CLEAR,  64'd0, 32'd0, 16'd0, 1'b1, ST_OK},
      '{OP_LOOKUP, 64'd5, 32'd0, 16'd0, 1'b1, ST_EMPTY},
      '{OP_FINGER, '1,    32'd0, 16'd0, 1'b1, ST_EMPTY},
      '{OP_INSERT, 64'd0, 32'd0, 16'd0, 1'b1, ST_OK},
      '{OP_INSERT, '1,    '1,    '1,    1'b1, ST_OK},
      '{OP_INSERT, 64'd0, 32'd0, 16'd0, 1'b1, ST_DUP},
      '{OP_INSERT, 64'd0, 32'd1, 16'd0, 1'b1, ST_COLL},
      '{OP_INSERT, '1,    '1,    16'd7, 1'b1, ST_COLL},
      '{OP_INSERT, 64'h8000_0000_0000_0000, 32'hC0A8_0001, 16'd8080, 1'b1, ST_OK},
      '{OP_LOOKUP, 64'd0, 32'd0, 16'd0, 1'b0, ST_OK},
      '{OP_LOOKUP, 64'd1, 32'd0, 16'd0, 1'b0, ST_OK},
      '{OP_LOOKUP, '1,    32'd0, 16'd0, 1'b0, ST_OK},
      '{OP_LOOKUP, 64'h8000_0000_0000_0001, 32'd0, 16'd0, 1'b0, ST_OK},
      '{OP_FINGER, 64'd0, 32'd0, 16'd0, 1'b0, ST_OK},
      '{OP_FINGER, '1,    32'd0, 16'd0, 1'b0, ST_OK},
      '{OP_CLEAR,  '1,    '1,    '1,    1'b1, ST_OK},
      '{OP_LOOKUP, 64'd0, 32'd0, 16'd0, 1'b1, ST_EMPTY},
      '{OP_FINGER, 64'd0, 32'd0, 16'd0, 1'b1, ST_EMPTY}
   };

   initial begin
      stim_row row;
      int n, wait_cycles;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_CLEAR;
      req_key = '0;
      req_member_addr = '0;
      req_member_port = '0;
      ring_count = 0;
      error_count = 0;
      cycle_count = 0;
      calm = 1'b0;
      long_hold = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         send_request(directed[i]);
         sender_gap();
      end

      // Fill the table to capacity, then probe the full-table cases.
      while (ring_count < MEMBERS) begin
         row = random_row(OP_INSERT);
         row.key = {$urandom, $urandom};
         send_request(row);
         sender_gap();
      end
      for (n = 0; n < 6; n++) begin
         send_request(random_row(OP_INSERT));
         sender_gap();
      end

      // The receiver holds off while a finger build and more requests pile up.
      long_hold = 1'b1;
      send_request(random_row(OP_FINGER));
      for (n = 0; n < 8; n++) send_request(random_row(OP_LOOKUP));
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);

      row = random_row(OP_CLEAR);
      send_request(row);
      for (n = 0; n < 100; n++) begin
         if (n == 80) calm = 1'b1;
         send_request(random_row(random_op()));
         sender_gap();
      end
      @(negedge clock);
      req_valid = 1'b0;

      wait_cycles = 0;
      while (pending_replies.size() != 0 && wait_cycles < 500_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_replies.size() == 0) begin
         $display("ring_successor_table_tb: done, clean");
      end else begin
         if (pending_replies.size() != 0)
            $error("%0d replies never arrived", pending_replies.size());
         $display("ring_successor_table_tb: done, errors");
      end
      $finish;
   end

endmodule
